[hw/rtl/aes256_ctr_stream_cipher_assert.svh]
// Assertion macros used by the checker of the AES-256 CTR block.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef AES256_CTR_STREAM_CIPHER_ASSERT_SVH
`define AES256_CTR_STREAM_CIPHER_ASSERT_SVH

// Antecedent implies consequent in the next cycle, ignored during reset.
`define ACTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle, ignored during reset.
`define ACTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/aes_ctr_pkg.sv]
// Package for the AES-256 CTR block: types, constants and the round functions.
// Used by the register file, controller, datapath and top level.
package aes_ctr_pkg;

  localparam int NUM_ROUNDS = 14;
  localparam int RK_ROWS    = 15;
  localparam logic [7:0] GF_REDUCE = 8'h1b;
  localparam logic [7:0] GF_TOP    = 8'h80;

  // Forward S-box, entry 0 in the top byte.
  localparam logic [2047:0] SBOX_FLAT = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_HI = 3'd4,
    REG_NONCE_LO = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_KEYEXP = 2'd1,
    ST_RUN    = 2'd2
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_take;
    logic       exp_en;
    logic [3:0] exp_row;
    logic [3:0] rd_row;
    logic       run_en;
    logic [3:0] rnd;
    logic       out_load;
  } dp_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [10:0] pos;
    pos = 11'd2047 - {b, 3'b000};
    return SBOX_FLAT[pos -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (((b & GF_TOP) != 8'h00) ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int k = 0; k < 16; k++) begin
      t[8*k +: 8] = sbox(s[8*k +: 8]);
    end
    return t;
  endfunction

  // Byte k of the state sits at bits 127-8k down to 120-8k.
  function automatic logic [127:0] row_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = s[127 - 8*(4*((c + r) % 4) + r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] column_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32*c -: 8];
      a1  = s[119 - 32*c -: 8];
      a2  = s[111 - 32*c -: 8];
      a3  = s[103 - 32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

[hw/rtl/aes_ctr_regs.sv]
// APB register file for the key and nonce of the AES-256 CTR block.
// Depends on aes_ctr_pkg for the register indexes.
module aes_ctr_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  output logic [255:0] key_o,
  output logic [95:0]  nonce_o,
  output logic         key_wr_o
);
  import aes_ctr_pkg::*;

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_hi_q;
  logic [31:0] nonce_lo_q;
  logic        key_wr_q, key_wr_d;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[5:3]);

  // Register writes; a key write flags a new expansion in the next cycle.
  always_comb begin
    key_wr_d = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_wr_d = 1'b1;
        default:                                key_wr_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_hi_q <= '0;
      nonce_lo_q <= '0;
      key_wr_q   <= 1'b0;
    end else begin
      key_wr_q <= key_wr_d;
      if (wr_en) begin
        case (idx)
          REG_KEY0:     key0_q     <= pwdata;
          REG_KEY1:     key1_q     <= pwdata;
          REG_KEY2:     key2_q     <= pwdata;
          REG_KEY3:     key3_q     <= pwdata;
          REG_NONCE_HI: nonce_hi_q <= pwdata;
          REG_NONCE_LO: nonce_lo_q <= pwdata[31:0];
          default: ;
        endcase
      end
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_KEY0:     prdata = key0_q;
      REG_KEY1:     prdata = key1_q;
      REG_KEY2:     prdata = key2_q;
      REG_KEY3:     prdata = key3_q;
      REG_NONCE_HI: prdata = nonce_hi_q;
      REG_NONCE_LO: prdata = {32'h0, nonce_lo_q};
      default:      prdata = '0;
    endcase
  end

  assign key_o    = {key0_q, key1_q, key2_q, key3_q};
  assign nonce_o  = {nonce_hi_q, nonce_lo_q};
  assign key_wr_o = key_wr_q;

endmodule

[hw/rtl/aes_ctr_ctrl.sv]
// Controller of the AES-256 CTR block: key expansion sequence, round count
// and the handshakes. Depends on aes_ctr_pkg.
module aes_ctr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 key_wr_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output aes_ctr_pkg::dp_cmd_t cmd_o
);
  import aes_ctr_pkg::*;

  localparam logic [3:0] LastRow = 4'(RK_ROWS - 1);

  ctrl_state_e state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.rnd     = cnt_q;
    cmd_o.exp_row = cnt_q;
    if (key_wr_i) begin
      state_d = ST_KEYEXP;
      cnt_d   = '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.in_take = 1'b1;
            cnt_d         = '0;
            state_d       = ST_RUN;
          end
        end
        ST_KEYEXP: begin
          cmd_o.exp_en = 1'b1;
          cnt_d        = cnt_q + 4'd1;
          if (cnt_q == LastRow) begin
            state_d = ST_IDLE;
          end
        end
        ST_RUN: begin
          if (cnt_q == LastRow) begin
            if (out_free) begin
              cmd_o.run_en   = 1'b1;
              cmd_o.out_load = 1'b1;
              out_valid_d    = 1'b1;
              state_d        = ST_IDLE;
            end
          end else begin
            cmd_o.run_en = 1'b1;
            cnt_d        = cnt_q + 4'd1;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
    // The round key memory is read in the cycle before its row is used.
    cmd_o.rd_row = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/aes_ctr_dp.sv]
// Datapath of the AES-256 CTR block: key schedule, round key memory, cipher
// state, block counter and output register. Depends on aes_ctr_pkg.
module aes_ctr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aes_ctr_pkg::dp_cmd_t cmd_i,
  input  logic [255:0]         key_i,
  input  logic [95:0]          nonce_i,
  input  logic [63:0]          data_high_i,
  input  logic [63:0]          data_low_i,
  input  logic [4:0]           valid_bytes_i,
  input  logic                 start_message_i,
  output logic [63:0]          out_high_o,
  output logic [63:0]          out_low_o,
  output logic [4:0]           out_valid_bytes_o
);
  import aes_ctr_pkg::*;

  localparam logic [3:0] LastRound = 4'(NUM_ROUNDS);

  logic [127:0] rk_mem [RK_ROWS];
  logic [127:0] rk_q;
  logic [255:0] win_q, win_d;
  logic [127:0] new_row, wr_row;
  logic [31:0]  temp;
  logic [7:0]   rcon;
  logic [127:0] st_q, st_d, rnd_out, sr;
  logic [127:0] data_q, ks_mask;
  logic [4:0]   vb_q;
  logic [31:0]  ctr_q, ctr_use;
  logic [63:0]  out_high_q, out_low_q;
  logic [4:0]   out_vb_q;

  // Four schedule words per step from the sliding eight-word window.
  always_comb begin
    rcon = 8'h01 << (cmd_i.exp_row[3:1] - 3'd1);
    if (!cmd_i.exp_row[0]) begin
      temp = sbox_word({win_q[23:0], win_q[31:24]}) ^ {rcon, 24'h0};
    end else begin
      temp = sbox_word(win_q[31:0]);
    end
    new_row[127:96] = win_q[255:224] ^ temp;
    new_row[95:64]  = win_q[223:192] ^ new_row[127:96];
    new_row[63:32]  = win_q[191:160] ^ new_row[95:64];
    new_row[31:0]   = win_q[159:128] ^ new_row[63:32];
    case (cmd_i.exp_row)
      4'd0: begin
        wr_row = key_i[255:128];
        win_d  = key_i;
      end
      4'd1: begin
        wr_row = win_q[127:0];
        win_d  = win_q;
      end
      default: begin
        wr_row = new_row;
        win_d  = {win_q[127:0], new_row};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_en) begin
      win_q <= win_d;
    end
  end

  // Round key memory: one row written per expansion step, one row read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_en) begin
      rk_mem[cmd_i.exp_row] <= wr_row;
    end
    rk_q <= rk_mem[cmd_i.rd_row];
  end

  // One cipher round per cycle while run_en is set; row zero is the plain key addition.
  always_comb begin
    sr = row_shift(sub_bytes(st_q));
    if (cmd_i.rnd == 4'd0) begin
      rnd_out = st_q ^ rk_q;
    end else if (cmd_i.rnd == LastRound) begin
      rnd_out = sr ^ rk_q;
    end else begin
      rnd_out = column_mix(sr) ^ rk_q;
    end
    ctr_use = start_message_i ? 32'h0 : ctr_q;
    st_d    = cmd_i.in_take ? {nonce_i, ctr_use} : rnd_out;
    for (int k = 0; k < 16; k++) begin
      ks_mask[127 - 8*k -: 8] = (vb_q > 5'(k)) ? (rnd_out[127 - 8*k -: 8] ^
                                data_q[127 - 8*k -: 8]) : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take || cmd_i.run_en) begin
      st_q <= st_d;
    end
    if (cmd_i.in_take) begin
      data_q <= {data_high_i, data_low_i};
      vb_q   <= valid_bytes_i;
    end
    if (cmd_i.out_load) begin
      out_high_q <= ks_mask[127:64];
      out_low_q  <= ks_mask[63:0];
      out_vb_q   <= vb_q;
    end
  end

  // Block counter advances once per transfer taken; a message start restarts it from zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (cmd_i.in_take) begin
      ctr_q <= ctr_use + 32'd1;
    end
  end

  assign out_high_o        = out_high_q;
  assign out_low_o         = out_low_q;
  assign out_valid_bytes_o = out_vb_q;

endmodule

[hw/rtl/aes256_ctr_stream_cipher.sv]
// Top level of the AES-256 counter-mode stream cipher.
// Depends on aes_ctr_pkg, aes_ctr_regs, aes_ctr_ctrl and aes_ctr_dp.
//
//   Channel  Signals                                   Direction
//   input    in_valid_i/in_ready_o, data, count, flag  in
//   output   out_valid_o/out_ready_i, result, count    out
//   config   APB psel..pready, 64-bit data, 8-byte map in/out
//
// A result is valid after its input transfer once the initial key addition and
// 14 rounds, one per cycle unless stalled, each with one row of the round key
// memory, are done. The input is ready again in the same cycle as the result
// is valid: one item at a time. A key write closes the input for its flag and
// 15 expansion steps. Reset clears the control state and the block counter;
// the round keys are undefined until a key is written. Behind a stalled result
// the next item runs up to its last round and waits with the input closed.
module aes256_ctr_stream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  input  logic [4:0]  valid_bytes_i,
  input  logic        start_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  output logic [4:0]  out_valid_bytes_o
);
  import aes_ctr_pkg::*;

  logic [255:0] key;
  logic [95:0]  nonce;
  logic         key_wr;
  dp_cmd_t      cmd;

  aes_ctr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key),
    .nonce_o (nonce),
    .key_wr_o(key_wr)
  );

  aes_ctr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_wr_i   (key_wr),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  aes_ctr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .key_i            (key),
    .nonce_i          (nonce),
    .data_high_i      (data_high_i),
    .data_low_i       (data_low_i),
    .valid_bytes_i    (valid_bytes_i),
    .start_message_i  (start_message_i),
    .out_high_o       (out_high_o),
    .out_low_o        (out_low_o),
    .out_valid_bytes_o(out_valid_bytes_o)
  );

endmodule

[hw/rtl/aes_ctr_chk.sv]
// Port-level checker for the AES-256 CTR block, bound to the top level.
// Depends on aes256_ctr_stream_cipher_assert.svh.
module aes_ctr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] out_high_o,
  input logic [63:0] out_low_o,
  input logic [4:0]  out_valid_bytes_o
);
  `include "aes256_ctr_stream_cipher_assert.svh"

  // A pending result stays until its transfer.
  `ACTR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  // A stalled result keeps its payload.
  `ACTR_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
    $stable(out_high_o) && $stable(out_low_o) && $stable(out_valid_bytes_o),
    "stalled result changed")
  // The block works on one item at a time.
  `ACTR_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second item taken")
  // No result can appear right after a transfer in.
  `ACTR_ASSERT_NEXT(a_no_early, in_valid_i && in_ready_o, !$rose(out_valid_o),
    "result too early")

endmodule

bind aes256_ctr_stream_cipher aes_ctr_chk u_chk (.*);
